FILE: sv/fbh_pkg.sv
// Shared types, constants and codes for the fanout bucket histogram.
package fbh_pkg;

    localparam int NUM_BUCKETS = 7;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int FANOUT_W    = 16;
    localparam int WL_W        = 32;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 48;
    localparam int SHARE_W     = 10;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int BCNT_W      = 3;
    localparam int PROD_W      = CNT_W + SHARE_W;
    localparam int DIV_W       = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    localparam logic [SHARE_W-1:0] SHARE_SCALE = SHARE_W'(1000);
    localparam logic [BCNT_W-1:0]  BUCKET_COUNT_RESET = BCNT_W'(7);
    localparam logic [FANOUT_W-1:0] BOUND_RESET [NUM_BUCKETS] =
        '{16'd2, 16'd3, 16'd4, 16'd5, 16'd10, 16'd20, 16'd40};

    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_FIRST  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LAST   = CFG_IDX_W'(NUM_BUCKETS);

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UPDATE,
        S_LOAD,
        S_START,
        S_DIV,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic pick;
        logic update;
        logic snap;
        logic div_start;
        logic respond;
        logic report;
        logic recorded;
        logic total_only;
        logic clear;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             small_fanout;
        logic             read_in_range;
        logic             div_busy;
    } t_dp_status;

endpackage

FILE: sv/fbh_div.sv
// Restoring divider, one quotient bit per cycle, saturating 32-bit quotient.
module fbh_div
    import fbh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DIV_W+15:0]      i_dividend,
    input  logic [DIV_W-1:0]       i_divisor,
    output logic                   o_busy,
    output logic [DIV_W-1:0]       o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_ovf;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_W:0]       w_trial;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_busy <= r_cnt != DIV_CNT_W'(1);
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= {16'b0, i_dividend[DIV_W+15:DIV_W]} >= i_divisor;
            r_rem <= {16'b0, i_dividend[DIV_W+15:DIV_W]};
            r_quo <= i_dividend[DIV_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_W'(w_trial - {1'b0, r_div}) : w_trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_ovf ? '1 : r_quo;

endmodule

FILE: sv/fbh_dp.sv
// Datapath: configuration, bucket store, bucket choice, dividers and result registers.
module fbh_dp
    import fbh_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl_cmd               i_ctrl,
    output t_dp_status              o_status,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [FANOUT_W-1:0]     i_fanout,
    input  logic [WL_W-1:0]         i_wirelength,
    input  logic [BKT_W-1:0]        i_read_bucket,
    output logic                    o_valid,
    output logic [BKT_W-1:0]        o_bucket,
    output logic                    o_recorded,
    output logic [CNT_W-1:0]        o_bucket_nets,
    output logic [SUM_W-1:0]        o_bucket_sum,
    output logic [WL_W-1:0]         o_bucket_min,
    output logic [WL_W-1:0]         o_bucket_max,
    output logic [DIV_W-1:0]        o_bucket_mean,
    output logic [SHARE_W-1:0]      o_share_tenths,
    output logic [CNT_W-1:0]        o_all_nets
);

    logic [BCNT_W-1:0]   r_bucket_count;
    logic [FANOUT_W-1:0] r_bounds [NUM_BUCKETS];

    logic [CMD_W-1:0]    r_cmd;
    logic [FANOUT_W-1:0] r_fanout;
    logic [WL_W-1:0]     r_wirelength;
    logic [BKT_W-1:0]    r_read_bucket;
    logic [BKT_W-1:0]    r_bucket;
    logic [PROD_W-1:0]   r_prod;

    logic [CNT_W-1:0]    r_net_counts  [NUM_BUCKETS];
    logic [SUM_W-1:0]    r_length_sums [NUM_BUCKETS];
    logic [WL_W-1:0]     r_length_mins [NUM_BUCKETS];
    logic [WL_W-1:0]     r_length_maxes[NUM_BUCKETS];
    logic [CNT_W-1:0]    r_total_nets;

    logic                r_out_valid;
    logic [BKT_W-1:0]    r_out_bucket;
    logic                r_out_recorded;
    logic [CNT_W-1:0]    r_out_nets;
    logic [SUM_W-1:0]    r_out_sum;
    logic [WL_W-1:0]     r_out_min;
    logic [WL_W-1:0]     r_out_max;
    logic [DIV_W-1:0]    r_out_mean;
    logic [SHARE_W-1:0]  r_out_share;
    logic [CNT_W-1:0]    r_out_all;

    logic [BCNT_W-1:0]   w_in_use;
    logic [BKT_W-1:0]    w_pick;
    logic [BKT_W-1:0]    w_sel;
    logic [SUM_W:0]      w_sum_next;
    logic                w_mean_busy;
    logic                w_share_busy;
    logic [DIV_W-1:0]    w_mean_q;
    logic [DIV_W-1:0]    w_share_q;
    logic                w_nonempty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RESET;
            r_bounds       <= BOUND_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_BUCKET_COUNT) begin
                r_bucket_count <= i_cfg_data[BCNT_W-1:0];
            end else if (i_cfg_index >= CFG_BOUND_FIRST && i_cfg_index <= CFG_BOUND_LAST) begin
                r_bounds[BKT_W'(i_cfg_index - CFG_BOUND_FIRST)] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (r_bucket_count == '0) begin
            w_in_use = BCNT_W'(1);
        end else if (r_bucket_count > BCNT_W'(NUM_BUCKETS)) begin
            w_in_use = BCNT_W'(NUM_BUCKETS);
        end else begin
            w_in_use = r_bucket_count;
        end
    end

    always_comb begin
        w_pick = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (BCNT_W'(i) < w_in_use && r_bounds[i] <= r_fanout) begin
                w_pick = BKT_W'(i);
            end
        end
    end

    // latch the item and pick the bucket
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd         <= i_command;
            r_fanout      <= i_fanout;
            r_wirelength  <= i_wirelength;
            r_read_bucket <= i_read_bucket;
        end
        if (!i_rst_n) begin
            r_bucket <= '0;
        end else if (i_ctrl.pick) begin
            r_bucket <= (r_cmd == CMD_READ) ? r_read_bucket : w_pick;
        end
        if (i_ctrl.snap) begin
            r_prod <= PROD_W'(r_net_counts[w_sel]) * PROD_W'(SHARE_SCALE);
        end
    end

    assign w_sel      = (r_bucket < BKT_W'(NUM_BUCKETS)) ? r_bucket : '0;
    assign w_sum_next = {1'b0, r_length_sums[w_sel]} + (SUM_W + 1)'(r_wirelength);
    assign w_nonempty = r_net_counts[w_sel] != '0;

    // bucket store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_net_counts[i]   <= '0;
                r_length_sums[i]  <= '0;
                r_length_mins[i]  <= '1;
                r_length_maxes[i] <= '0;
            end
            r_total_nets <= '0;
        end else if (i_ctrl.update) begin
            if (r_net_counts[w_sel] != '1) begin
                r_net_counts[w_sel] <= r_net_counts[w_sel] + CNT_W'(1);
            end
            if (r_total_nets != '1) begin
                r_total_nets <= r_total_nets + CNT_W'(1);
            end
            r_length_sums[w_sel] <= w_sum_next[SUM_W] ? '1 : w_sum_next[SUM_W-1:0];
            if (r_wirelength < r_length_mins[w_sel]) begin
                r_length_mins[w_sel] <= r_wirelength;
            end
            if (r_wirelength > r_length_maxes[w_sel]) begin
                r_length_maxes[w_sel] <= r_wirelength;
            end
        end
    end

    fbh_div u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_dividend (r_length_sums[w_sel]),
        .i_divisor  (r_net_counts[w_sel]),
        .o_busy     (w_mean_busy),
        .o_quotient (w_mean_q)
    );

    fbh_div u_share_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_dividend (SUM_W'(r_prod)),
        .i_divisor  (r_total_nets),
        .o_busy     (w_share_busy),
        .o_quotient (w_share_q)
    );

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctrl.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.respond) begin
            r_out_bucket   <= (i_ctrl.report || i_ctrl.total_only) ? r_bucket : '0;
            r_out_recorded <= i_ctrl.recorded;
            r_out_nets     <= i_ctrl.report ? r_net_counts[w_sel] : '0;
            r_out_sum      <= i_ctrl.report ? r_length_sums[w_sel] : '0;
            r_out_min      <= (i_ctrl.report && w_nonempty) ? r_length_mins[w_sel] : '0;
            r_out_max      <= (i_ctrl.report && w_nonempty) ? r_length_maxes[w_sel] : '0;
            r_out_mean     <= (i_ctrl.report && w_nonempty) ? w_mean_q : '0;
            if (i_ctrl.report && r_total_nets != '0) begin
                r_out_share <= (w_share_q > DIV_W'(SHARE_SCALE)) ? SHARE_SCALE
                                                                 : w_share_q[SHARE_W-1:0];
            end else begin
                r_out_share <= '0;
            end
            r_out_all <= (i_ctrl.report || i_ctrl.total_only) ? r_total_nets : '0;
        end
    end

    assign o_status.cmd           = r_cmd;
    assign o_status.small_fanout  = r_fanout[FANOUT_W-1:1] == '0;
    assign o_status.read_in_range = r_read_bucket < BKT_W'(NUM_BUCKETS);
    assign o_status.div_busy      = w_mean_busy || w_share_busy;

    assign o_valid        = r_out_valid;
    assign o_bucket       = r_out_bucket;
    assign o_recorded     = r_out_recorded;
    assign o_bucket_nets  = r_out_nets;
    assign o_bucket_sum   = r_out_sum;
    assign o_bucket_min   = r_out_min;
    assign o_bucket_max   = r_out_max;
    assign o_bucket_mean  = r_out_mean;
    assign o_share_tenths = r_out_share;
    assign o_all_nets     = r_out_all;

    a_total_covers_bucket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total_nets >= r_net_counts[w_sel])
        else $error("total net count below a bucket count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> r_total_nets == '0 && r_net_counts[0] == '0)
        else $error("clear left counts behind");

    a_update_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.update && r_total_nets != '1 |=> r_total_nets == $past(r_total_nets) + CNT_W'(1))
        else $error("record did not advance the total");

endmodule

FILE: sv/fbh_ctrl.sv
// Controller state machine sequencing decode, update, division and response.
module fbh_ctrl
    import fbh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_ctrl,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;
    logic   w_is_record;
    logic   w_is_read;

    assign w_is_record = i_status.cmd == CMD_RECORD && !i_status.small_fanout;
    assign w_is_read   = i_status.cmd == CMD_READ && i_status.read_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (w_is_record) begin
                    n_state = S_UPDATE;
                end else if (w_is_read) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_UPDATE: n_state = S_LOAD;
            S_LOAD:   n_state = S_START;
            S_START:  n_state = S_DIV;
            S_DIV: begin
                if (!i_status.div_busy) n_state = S_RESP;
            end
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            S_IDLE:   o_ctrl.load      = i_start;
            S_DECODE: o_ctrl.pick      = 1'b1;
            S_UPDATE: o_ctrl.update    = 1'b1;
            S_LOAD:   o_ctrl.snap      = 1'b1;
            S_START:  o_ctrl.div_start = 1'b1;
            S_RESP: begin
                o_ctrl.respond    = 1'b1;
                o_ctrl.report     = w_is_record || w_is_read;
                o_ctrl.recorded   = w_is_record;
                o_ctrl.total_only = i_status.cmd == CMD_READ && !i_status.read_in_range;
                o_ctrl.clear      = i_status.cmd == CMD_CLEAR;
            end
            default: o_ctrl = '0;
        endcase
    end

    assign o_busy = r_state != S_IDLE;

    a_resp_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.respond |=> r_state == S_IDLE)
        else $error("response not followed by idle");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.div_start |=> r_state == S_DIV && i_status.div_busy)
        else $error("dividers not running after start");

endmodule

FILE: sv/fanout_bucket_histogram.sv
// Top level of the fanout bucket histogram: controller plus datapath.
//
// Each item is taken when start is high and busy is low, and yields exactly one
// result beat on o_valid in the first cycle that busy is low again; the receiver
// has no way to stall it. A record (fanout of two or more) and an in-range read
// both run the bucket's mean and share through a pair of 32-step restoring
// dividers and stay busy until both dividers finish. Clear, an ignored record,
// an out-of-range read or an unused command skip the dividers. Configuration
// writes are always ready and must be made only while the block is idle.
module fanout_bucket_histogram
    import fbh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [FANOUT_W-1:0]   i_fanout,
    input  logic [WL_W-1:0]       i_wirelength,
    input  logic [BKT_W-1:0]      i_read_bucket,
    output logic                  o_valid,
    output logic [BKT_W-1:0]      o_bucket,
    output logic                  o_recorded,
    output logic [CNT_W-1:0]      o_bucket_nets,
    output logic [SUM_W-1:0]      o_bucket_sum,
    output logic [WL_W-1:0]       o_bucket_min,
    output logic [WL_W-1:0]       o_bucket_max,
    output logic [DIV_W-1:0]      o_bucket_mean,
    output logic [SHARE_W-1:0]    o_share_tenths,
    output logic [CNT_W-1:0]      o_all_nets
);

    t_ctrl_cmd  w_ctrl;
    t_dp_status w_status;
    logic       w_busy;

    assign busy        = w_busy;
    assign o_cfg_ready = 1'b1;

    fbh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_ctrl   (w_ctrl),
        .o_busy   (w_busy)
    );

    fbh_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_status       (w_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_fanout       (i_fanout),
        .i_wirelength   (i_wirelength),
        .i_read_bucket  (i_read_bucket),
        .o_valid        (o_valid),
        .o_bucket       (o_bucket),
        .o_recorded     (o_recorded),
        .o_bucket_nets  (o_bucket_nets),
        .o_bucket_sum   (o_bucket_sum),
        .o_bucket_min   (o_bucket_min),
        .o_bucket_max   (o_bucket_max),
        .o_bucket_mean  (o_bucket_mean),
        .o_share_tenths (o_share_tenths),
        .o_all_nets     (o_all_nets)
    );

endmodule
